/* sv/sirs_pkg.sv */
// Package for the signed integer to radix symbol converter: widths, codes, constant tables.
`default_nettype none
package sirs_pkg;

  localparam int VALUE_W     = 32;
  localparam int SYMBOL_W    = 8;
  localparam int RADIX_W     = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int RECIP_W     = 32;
  localparam int TABLE_SIZE  = 16;

  localparam int DEF_MAX_BASE   = 16;
  localparam int DEF_VALUE_BITS = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_RADIX        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] WS_LOW    = 8'd9;
  localparam logic [SYMBOL_W-1:0] WS_HIGH   = 8'd13;
  localparam logic [SYMBOL_W-1:0] WS_SPACE  = 8'd32;

  // floor(2^32 / b); quotient estimate is low by at most one
  function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] b);
    logic [RECIP_W-1:0] r;
    case (b)
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd14:   r = 32'h1249_2492;
      5'd15:   r = 32'h1111_1111;
      5'd16:   r = 32'h1000_0000;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic sym_legal(input logic [SYMBOL_W-1:0] c);
    return (c != '0) && (c != SYM_PLUS) && (c != SYM_MINUS) && (c != WS_SPACE) &&
           !((c >= WS_LOW) && (c <= WS_HIGH));
  endfunction

endpackage
`default_nettype wire

/* sv/signed_int_to_radix_symbols.sv */
// Signed integer to radix symbol converter, top level.
//
// A request is taken on the rising edge where start is high and busy is low;
// value carries a two's complement integer (low VALUE_BITS bits used). The
// block then emits its text one byte per cycle on symbol, each marked by a
// one-cycle strobe: a leading '-' for negative values, then the digit symbols
// most significant first; last flags the final byte. The receiver cannot stall.
// Configuration (radix, symbols_low, symbols_high at indexes 0..2) is written
// through cfg_write/cfg_index/cfg_data; the user must write it only while the
// block is idle, as the block itself does not enforce this.
// With radix outside 2..MAX_BASE the request finishes at once with no output;
// an alphabet with an illegal or repeated symbol gives no output either.
// One shared 32x32 reciprocal multiplier (state MUL) and a remainder-fix step
// (state FIX) produce each digit; division and the alphabet scan run side by
// side, then the block sends the sign if negative, then the digit symbols.
// Reset returns the sequencer to idle and clears the configuration, scan,
// strobe, last and digit-count registers to 0; datapath registers are not reset.
`default_nettype none
module signed_int_to_radix_symbols #(
  parameter int MAX_BASE   = sirs_pkg::DEF_MAX_BASE,
  parameter int VALUE_BITS = sirs_pkg::DEF_VALUE_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [sirs_pkg::VALUE_W-1:0]     value,
  output logic                                  strobe,
  output logic      [sirs_pkg::SYMBOL_W-1:0]    symbol,
  output logic                                  last,
  input  wire logic                             cfg_write,
  input  wire logic [sirs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sirs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int MAG_W = VALUE_BITS;
  localparam int DIG_W = $clog2(MAX_BASE);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int REM_W = 6;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_FIX  = 6'b000100,
    ST_WAIT = 6'b001000,
    ST_SIGN = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state;

  logic [sirs_pkg::RADIX_W-1:0]    radix;
  logic [sirs_pkg::CFG_DATA_W-1:0] symbols_low;
  logic [sirs_pkg::CFG_DATA_W-1:0] symbols_high;

  logic [MAG_W-1:0]             mag;
  logic                         neg;
  logic [sirs_pkg::RECIP_W-1:0] prod_hi;
  logic [VALUE_BITS*DIG_W-1:0]  stack;
  logic [CNT_W-1:0]             ndig;
  logic [sirs_pkg::RADIX_W-1:0] chk_idx;
  logic                         chk_done;
  logic                         chk_ok;

  logic [sirs_pkg::TABLE_SIZE-1:0][sirs_pkg::SYMBOL_W-1:0] sym_tab;
  assign sym_tab = {symbols_high, symbols_low};

  // radix range
  logic radix_ok;
  assign radix_ok = (radix >= 5'd2) && (radix <= sirs_pkg::RADIX_W'(MAX_BASE));

  // input sign and magnitude
  logic [MAG_W-1:0] v_in;
  logic             neg_in;
  logic [MAG_W-1:0] mag_in;
  assign v_in   = value[MAG_W-1:0];
  assign neg_in = v_in[MAG_W-1];
  assign mag_in = neg_in ? (~v_in + MAG_W'(1)) : v_in;

  // quotient estimate
  logic [sirs_pkg::RECIP_W-1:0]   mag_ext;
  logic [2*sirs_pkg::RECIP_W-1:0] prod;
  assign mag_ext = sirs_pkg::RECIP_W'(mag);
  assign prod    = mag_ext * sirs_pkg::recip(radix);

  // remainder fix
  logic [MAG_W-1:0] q_est;
  logic [MAG_W-1:0] qb;
  logic [MAG_W-1:0] rem_full;
  logic [REM_W-1:0] rem;
  logic             rem_ge;
  logic [REM_W-1:0] rem_corr;
  logic [MAG_W-1:0] q;
  logic [DIG_W-1:0] digit;
  assign q_est    = prod_hi[MAG_W-1:0];
  assign qb       = q_est * MAG_W'(radix);
  assign rem_full = mag - qb;
  assign rem      = rem_full[REM_W-1:0];
  assign rem_ge   = rem >= REM_W'(radix);
  assign rem_corr = rem_ge ? (rem - REM_W'(radix)) : rem;
  assign q        = rem_ge ? (q_est + MAG_W'(1)) : q_est;
  assign digit    = rem_corr[DIG_W-1:0];

  // alphabet scan, one symbol a cycle
  logic [sirs_pkg::SYMBOL_W-1:0] chk_sym;
  logic                          chk_dup;
  assign chk_sym = sym_tab[chk_idx[3:0]];
  always_comb begin
    chk_dup = 1'b0;
    for (int j = 0; j < sirs_pkg::TABLE_SIZE; j++) begin
      if ((sirs_pkg::RADIX_W'(j) > chk_idx) && (sirs_pkg::RADIX_W'(j) < radix) &&
          (sym_tab[j] == chk_sym)) begin
        chk_dup = 1'b1;
      end
    end
  end

  logic [DIG_W-1:0] top;
  assign top = stack[DIG_W-1:0];

  assign busy = (state != ST_IDLE);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sirs_pkg::REG_RADIX:        radix        <= cfg_data[sirs_pkg::RADIX_W-1:0];
        sirs_pkg::REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        sirs_pkg::REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // alphabet scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_idx  <= '0;
      chk_done <= 1'b0;
      chk_ok   <= 1'b0;
    end else if (state == ST_IDLE) begin
      chk_idx  <= '0;
      chk_done <= 1'b0;
      chk_ok   <= 1'b1;
    end else if (!chk_done) begin
      if (chk_idx >= radix) begin
        chk_done <= 1'b1;
      end else begin
        if (!sirs_pkg::sym_legal(chk_sym) || chk_dup) begin
          chk_ok <= 1'b0;
        end
        chk_idx <= chk_idx + sirs_pkg::RADIX_W'(1);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
      last   <= 1'b0;
      ndig   <= '0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start && radix_ok) begin
            mag   <= mag_in;
            neg   <= neg_in;
            ndig  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_hi <= prod[2*sirs_pkg::RECIP_W-1:sirs_pkg::RECIP_W];
          state   <= ST_FIX;
        end
        ST_FIX: begin
          stack <= {stack[VALUE_BITS*DIG_W-DIG_W-1:0], digit};
          mag   <= q;
          ndig  <= ndig + CNT_W'(1);
          if ((q == '0) || (ndig == CNT_W'(VALUE_BITS))) begin
            state <= ST_WAIT;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_WAIT: begin
          if (chk_done) begin
            if (!chk_ok) begin
              state <= ST_IDLE;
            end else if (neg) begin
              state <= ST_SIGN;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_SIGN: begin
          strobe <= 1'b1;
          symbol <= sirs_pkg::SYM_MINUS;
          state  <= ST_EMIT;
        end
        ST_EMIT: begin
          strobe <= 1'b1;
          symbol <= sym_tab[4'(top)];
          last   <= (ndig == CNT_W'(1));
          stack  <= stack >> DIG_W;
          ndig   <= ndig - CNT_W'(1);
          if (ndig == CNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ($past(state) == ST_SIGN || $past(state) == ST_EMIT))
    else $error("strobe without an output step");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIX) |-> (rem_corr < REM_W'(radix)))
    else $error("remainder fix left digit out of range");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && radix_ok) |=> busy)
    else $error("request with valid radix not started");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("output after last symbol");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for signed_int_to_radix_symbols: directed table, then randomized conversions.
module tb;
  import sirs_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 120;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  // alphabet table indexes
  localparam int AL_RESET = 0;
  localparam int AL_DEC   = 1;
  localparam int AL_HEX   = 2;
  localparam int AL_BIN   = 3;
  localparam int AL_TERN  = 4;
  localparam int AL_HIGH  = 5;
  localparam int AL_R1    = 6;
  localparam int AL_R17   = 7;
  localparam int AL_R31   = 8;
  localparam int AL_PLUS  = 9;
  localparam int AL_MINUS = 10;
  localparam int AL_CR    = 11;
  localparam int AL_SPACE = 12;
  localparam int AL_ZERO  = 13;
  localparam int AL_DUP   = 14;
  localparam int AL_TAB   = 15;

  typedef struct packed {
    logic [SYMBOL_W-1:0] sym;
    logic                last;
  } char_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] rd;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
  } alph_t;

  typedef struct {
    int              alph;
    logic [VALUE_W-1:0] v;
    bit              typed;
    string           txt;
  } row_t;

  alph_t alphabets [16] = '{
    '{64'd0,  64'h0,                   64'h0},
    '{64'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938},
    '{64'd16, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938},
    '{64'd2,  64'h0020_2B2D_0A09_3130, 64'h2D2D_2D2D_2D2D_2D2D},
    '{64'hFFFF_FFFF_FFFF_FFE3, 64'h2020_2020_207A_7978, 64'h0},
    '{64'd16, 64'hF7F6_F5F4_F3F2_F1F0, 64'hFFFE_FDFC_FBFA_F9F8},
    '{64'd1,  64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938},
    '{64'd17, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938},
    '{64'd31, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938},
    '{64'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_2B38},
    '{64'd16, 64'h3736_3534_3332_3130, 64'h2D65_6463_6261_3938},
    '{64'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_0D38},
    '{64'd10, 64'h3736_2034_3332_3130, 64'h0000_0000_0000_3938},
    '{64'd10, 64'h3736_3534_0032_3130, 64'h0000_0000_0000_3938},
    '{64'd16, 64'h3736_3534_3332_3130, 64'h3065_6463_6261_3938},
    '{64'd16, 64'h3736_3534_3332_3130, 64'h6665_6409_6261_3938}
  };

  row_t script [24] = '{
    '{AL_RESET, 32'h0000_002A, 1'b1, ""},
    '{AL_DEC,   32'h0000_0000, 1'b1, "0"},
    '{AL_DEC,   32'h8000_0000, 1'b1, "-2147483648"},
    '{AL_DEC,   32'h7FFF_FFFF, 1'b1, "2147483647"},
    '{AL_DEC,   32'hFFFF_FFFF, 1'b1, "-1"},
    '{AL_HEX,   32'hFFFF_FFFF, 1'b1, "-1"},
    '{AL_HEX,   32'h7FFF_FFFF, 1'b1, "7fffffff"},
    '{AL_HEX,   32'h8000_0000, 1'b1, "-80000000"},
    '{AL_BIN,   32'h8000_0000, 1'b1, "-10000000000000000000000000000000"},
    '{AL_BIN,   32'h7FFF_FFFF, 1'b1, "1111111111111111111111111111111"},
    '{AL_BIN,   32'h0000_0002, 1'b1, "10"},
    '{AL_TERN,  32'hFFFF_FFF9, 1'b1, "-zy"},
    '{AL_HIGH,  32'h89AB_CDEF, 1'b0, ""},
    '{AL_HIGH,  32'h0123_4567, 1'b0, ""},
    '{AL_R1,    32'h0000_0007, 1'b1, ""},
    '{AL_R17,   32'h8000_0000, 1'b1, ""},
    '{AL_R31,   32'h7FFF_FFFF, 1'b1, ""},
    '{AL_PLUS,  32'hFFFF_FFFF, 1'b1, ""},
    '{AL_MINUS, 32'h0000_0000, 1'b1, ""},
    '{AL_CR,    32'h8000_0000, 1'b1, ""},
    '{AL_SPACE, 32'h0000_0005, 1'b1, ""},
    '{AL_ZERO,  32'h1234_5678, 1'b1, ""},
    '{AL_DUP,   32'hFFFF_FFF0, 1'b1, ""},
    '{AL_TAB,   32'h7FFF_FFFF, 1'b1, ""}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [VALUE_W-1:0] value = '0;
  logic strobe;
  logic [SYMBOL_W-1:0] symbol;
  logic last;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model copy of the registers
  logic [RADIX_W-1:0] radix_reg = '0;
  logic [2*CFG_DATA_W-1:0] table_reg = '0;

  char_t pending_chars [$];
  int errors = 0;
  int cycle_count = 0;

  signed_int_to_radix_symbols u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .symbol    (symbol),
    .last      (last),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic bit legal_symbol(input logic [SYMBOL_W-1:0] c);
    bit bad;
    bad = (c == 8'h00) || (c == SYM_PLUS) || (c == SYM_MINUS) || (c == WS_SPACE) ||
          ((c >= WS_LOW) && (c <= WS_HIGH));
    return !bad;
  endfunction

  function automatic bit alphabet_usable();
    int n;
    logic [SYMBOL_W-1:0] c;
    n = int'(radix_reg);
    if (n < 2 || n > DEF_MAX_BASE) return 1'b0;
    for (int i = 0; i < n; i++) begin
      c = table_reg[8*i +: 8];
      if (!legal_symbol(c)) return 1'b0;
      for (int j = i + 1; j < n; j++)
        if (table_reg[8*j +: 8] == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // expected symbols of one conversion under the current alphabet
  function automatic void spell_value(input logic [VALUE_W-1:0] v);
    logic [VALUE_W:0] mag;
    logic [VALUE_W:0] base;
    int digits [VALUE_W+1];
    int nd;
    if (!alphabet_usable()) return;
    base = {28'd0, radix_reg};
    mag = v[VALUE_W-1] ? ({1'b0, ~v} + 33'd1) : {1'b0, v};
    nd = 0;
    do begin
      digits[nd] = int'(mag % base);
      mag = mag / base;
      nd++;
    end while (mag != 0);
    if (v[VALUE_W-1]) pending_chars.push_back('{SYM_MINUS, 1'b0});
    for (int k = nd - 1; k >= 0; k--)
      pending_chars.push_back('{table_reg[8*digits[k] +: 8], k == 0});
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      pending_chars.push_back('{s[i], i == s.len() - 1});
  endfunction

  function automatic void flag_mismatch(input string what, input char_t want, input char_t got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s: expected sym %h last %b, got sym %h last %b",
               $realtime, what, want.sym, want.last, got.sym, got.last);
  endfunction

  always @(posedge clk) begin : check_output
    char_t got;
    char_t want;
    if (!rst && strobe) begin
      got = '{symbol, last};
      if (pending_chars.size() == 0) begin
        flag_mismatch("unexpected symbol", '0, got);
      end else begin
        want = pending_chars.pop_front();
        if (got.sym !== want.sym || got.last !== want.last)
          flag_mismatch("symbol mismatch", want, got);
      end
    end
  end

  // park the block: no request in flight, all output drained
  task automatic settle();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_alphabet(input alph_t a);
    int first;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] d;
    settle();
    first = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      case ((first + i) % 3)
        0: begin idx = REG_RADIX; d = a.rd; end
        1: begin idx = REG_SYMBOLS_LOW; d = a.lo; end
        default: begin idx = REG_SYMBOLS_HIGH; d = a.hi; end
      endcase
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data <= d;
      @(posedge clk);
      case (idx)
        REG_RADIX: radix_reg = d[RADIX_W-1:0];
        REG_SYMBOLS_LOW: table_reg[63:0] = d;
        REG_SYMBOLS_HIGH: table_reg[127:64] = d;
        default: ;
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_UNUSED;
      cfg_data <= {$urandom, $urandom};
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic send_request(input logic [VALUE_W-1:0] v, input int idle_pct,
                              input bit typed, input string txt);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed) push_text(txt);
    else spell_value(v);
  endtask

  function automatic alph_t random_alphabet();
    alph_t a;
    logic [SYMBOL_W-1:0] tbl [16];
    bit used [256];
    int r;
    int i;
    int k;
    logic [SYMBOL_W-1:0] c;
    case ($urandom_range(0, 9))
      0: r = 2;
      1: r = 16;
      default: r = $urandom_range(2, 16);
    endcase
    foreach (used[n]) used[n] = 1'b0;
    foreach (tbl[n]) tbl[n] = SYMBOL_W'($urandom_range(0, 255));
    for (i = 0; i < r; i++) begin
      do c = SYMBOL_W'($urandom_range(1, 255)); while (!legal_symbol(c) || used[c]);
      used[c] = 1'b1;
      tbl[i] = c;
    end
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(0, 8);
      case (k)
        5: c = SYM_PLUS;
        6: c = SYM_MINUS;
        7: c = WS_SPACE;
        8: c = 8'h00;
        default: c = SYMBOL_W'(WS_LOW + k);
      endcase
      case ($urandom_range(0, 3))
        0: r = $urandom_range(0, 1) ? $urandom_range(17, 31) : $urandom_range(0, 1);
        1: tbl[$urandom_range(0, r - 1)] = c;
        2: begin
          i = $urandom_range(1, r - 1);
          tbl[i] = tbl[$urandom_range(0, i - 1)];
        end
        default: tbl[r - 1] = c;
      endcase
    end
    a.rd = {$urandom, $urandom};
    a.rd[RADIX_W-1:0] = RADIX_W'(r);
    for (i = 0; i < 8; i++) begin
      a.lo[8*i +: 8] = tbl[i];
      a.hi[8*i +: 8] = tbl[8 + i];
    end
    return a;
  endfunction

  function automatic logic [VALUE_W-1:0] random_value(input int r);
    logic [63:0] p;
    logic [VALUE_W-1:0] v;
    int k;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h0000_0001;
          3: v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      1, 2: begin
        if (r < 2) begin
          v = $urandom;
        end else begin
          p = 64'd1;
          k = $urandom_range(1, 31);
          while (k > 0 && p * r <= 64'h8000_0000) begin
            p = p * r;
            k--;
          end
          v = $urandom_range(0, 1) ? p[31:0] : p[31:0] - 32'd1;
          if ($urandom_range(0, 1)) v = -v;
        end
      end
      3: begin
        v = $urandom_range(0, 300);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int idle_pcts [4];
    int cur_alph;
    int valid_sent;
    int n;
    alph_t a;
    idle_pcts = '{0, 72, 0, 38};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_alph = AL_RESET;
    foreach (script[i]) begin
      if (script[i].alph != cur_alph) begin
        load_alphabet(alphabets[script[i].alph]);
        cur_alph = script[i].alph;
      end
      send_request(script[i].v, 0, script[i].typed, script[i].txt);
    end

    for (int ph = 0; ph < 4; ph++) begin
      valid_sent = 0;
      while (valid_sent < 125) begin
        a = random_alphabet();
        load_alphabet(a);
        n = alphabet_usable() ? $urandom_range(15, 35) : 4;
        for (int i = 0; i < n; i++)
          send_request(random_value(int'(radix_reg)), idle_pcts[ph], 1'b0, "");
        if (alphabet_usable()) valid_sent += n;
      end
    end

    settle();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
